[sv/avf_pkg.sv]
// ----------------------------------------------------------------------------
// avf_pkg: shared types and constants for altitude variance fusion
// Register map, health and confidence codes, and the pipeline record.
// ----------------------------------------------------------------------------
package avf_pkg;

   localparam int unsigned VAR_BIAS    = 6554;
   localparam int unsigned ERROR_LIMIT = 10;
   localparam int unsigned ONE_Q16     = 65536;

   // quotient bits per division and pipeline stage plan
   localparam int DIV_BITS   = 17;
   localparam int DIV1_FIRST = 1;
   localparam int SETUP2     = DIV1_FIRST + DIV_BITS;
   localparam int DIV2_FIRST = SETUP2 + 1;
   localparam int MUL1       = DIV2_FIRST + DIV_BITS;
   localparam int MUL2       = MUL1 + 1;
   localparam int FINAL      = MUL2 + 1;
   localparam int NSTAGE     = FINAL + 1;

   typedef enum logic [1:0] {
      REG_FUSION_ENABLE = 2'd0,
      REG_MIN_WEIGHT    = 2'd1,
      REG_STALE_TIMEOUT = 2'd2,
      REG_AGREE_THRESH  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      HEALTH_OK       = 2'd0,
      HEALTH_DEGRADED = 2'd1,
      HEALTH_STALE    = 2'd2,
      HEALTH_FAILED   = 2'd3
   } health_type;

   typedef enum logic [1:0] {
      CONF_NONE     = 2'd0,
      CONF_SINGLE   = 2'd1,
      CONF_DISAGREE = 2'd2,
      CONF_AGREE    = 2'd3
   } conf_type;

   typedef struct packed {
      logic signed [31:0] ba;
      logic signed [31:0] ga;
      logic [31:0]        bv;
      logic [31:0]        gv;
      logic               bok;
      logic               gok;
      logic               fuse;
      health_type         bh;
      health_type         gh;
      conf_type           conf;
      logic [49:0]        rem;
      logic [33:0]        den;
      logic [16:0]        quo;
      logic [16:0]        wb;
      logic [16:0]        wg;
      logic signed [48:0] pba;
      logic signed [48:0] pga;
      logic [48:0]        pbv;
      logic [48:0]        pgv;
      logic signed [31:0] alt;
      logic [33:0]        tb;
      logic [33:0]        tg;
      logic [31:0]        var_out;
      logic [1:0]         degree;
   } pipe_type;

endpackage

[sv/altitude_variance_fusion.sv]
// ----------------------------------------------------------------------------
// altitude_variance_fusion: inverse variance weighted altitude fusion
// Fuses one barometer and one GPS altitude sample per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the req_ channel carries both sensor samples. One response
//   on the rsp_ channel carries fused altitude, fused variance, fusion
//   degree, per-sensor health and agreement confidence.
//   Throughput is one request per cycle while responses are taken. The
//   pipeline has 39 register stages: one entry stage (loaded at the
//   accepting edge), a 17-stage restoring divider (weight normalization),
//   one floor stage, a second 17-stage divider (renormalization), two
//   multiply stages and one output stage.
//   All stages move together; when the response is not taken, the whole
//   pipeline holds and req_ready drops, and nothing is lost or repeated.
//   Reset empties the pipeline and loads the register defaults
//   (fusion on, min weight 6554, stale timeout 1000000 us, agree 5 m).
//   Registers sit on an APB-style port at byte addresses 0, 4, 8, 12 and
//   should be written only while no request is in flight.
// ----------------------------------------------------------------------------
module altitude_variance_fusion (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_baro_alt,
   input  logic [31:0]         req_baro_var,
   input  logic                req_baro_valid,
   input  logic [31:0]         req_baro_age_us,
   input  logic [15:0]         req_baro_errors,
   input  logic signed [31:0]  req_gps_alt,
   input  logic [31:0]         req_gps_var,
   input  logic                req_gps_valid,
   input  logic [31:0]         req_gps_age_us,
   input  logic [15:0]         req_gps_errors,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_fused_alt,
   output logic [31:0]         rsp_fused_var,
   output logic [1:0]          rsp_fusion_degree,
   output logic [1:0]          rsp_baro_health,
   output logic [1:0]          rsp_gps_health,
   output logic [1:0]          rsp_confidence,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import avf_pkg::*;

   logic        fusion_enable_ff;
   logic [15:0] min_weight_ff;
   logic [31:0] stale_timeout_ff;
   logic [31:0] agree_thresh_ff;

   pipe_type pipe_ff [NSTAGE];
   pipe_type pipe_in [NSTAGE];
   logic [NSTAGE-1:0] valid_ff;
   logic advance;

   assign pready  = 1'b1;
   assign advance = !valid_ff[NSTAGE-1] || rsp_ready;
   assign req_ready = advance && !reset;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fusion_enable_ff <= 1'b1;
         min_weight_ff    <= 16'd6554;
         stale_timeout_ff <= 32'd1000000;
         agree_thresh_ff  <= 32'd327680;
      end else if (psel && penable && pwrite) begin
         unique case (reg_index_type'(paddr[3:2]))
            REG_FUSION_ENABLE: fusion_enable_ff <= pwdata[0];
            REG_MIN_WEIGHT:    min_weight_ff    <= pwdata[15:0];
            REG_STALE_TIMEOUT: stale_timeout_ff <= pwdata;
            REG_AGREE_THRESH:  agree_thresh_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[3:2]))
         REG_FUSION_ENABLE: prdata = {31'd0, fusion_enable_ff};
         REG_MIN_WEIGHT:    prdata = {16'd0, min_weight_ff};
         REG_STALE_TIMEOUT: prdata = stale_timeout_ff;
         REG_AGREE_THRESH:  prdata = agree_thresh_ff;
         default:           prdata = 32'd0;
      endcase
   end

   // ---------------- entry stage ----------------
   always_comb begin
      logic signed [32:0] diff;
      logic [32:0]        adiff;
      logic [33:0]        den;
      pipe_in[0] = '0;
      pipe_in[0].ba  = req_baro_alt;
      pipe_in[0].ga  = req_gps_alt;
      pipe_in[0].bv  = req_baro_var;
      pipe_in[0].gv  = req_gps_var;
      pipe_in[0].bok = req_baro_valid;
      pipe_in[0].gok = req_gps_valid;
      pipe_in[0].fuse = req_baro_valid && req_gps_valid && fusion_enable_ff;

      if (req_baro_age_us > stale_timeout_ff)
         pipe_in[0].bh = HEALTH_STALE;
      else if (req_baro_errors > 16'(ERROR_LIMIT))
         pipe_in[0].bh = HEALTH_FAILED;
      else if (!req_baro_valid && req_baro_errors != 16'd0)
         pipe_in[0].bh = HEALTH_DEGRADED;
      else
         pipe_in[0].bh = HEALTH_OK;

      if (req_gps_age_us > stale_timeout_ff)
         pipe_in[0].gh = HEALTH_STALE;
      else if (req_gps_errors > 16'(ERROR_LIMIT))
         pipe_in[0].gh = HEALTH_FAILED;
      else if (!req_gps_valid && req_gps_errors != 16'd0)
         pipe_in[0].gh = HEALTH_DEGRADED;
      else
         pipe_in[0].gh = HEALTH_OK;

      diff  = 33'(req_baro_alt) - 33'(req_gps_alt);
      adiff = diff[32] ? 33'(-diff) : 33'(diff);
      if (!req_baro_valid && !req_gps_valid)
         pipe_in[0].conf = CONF_NONE;
      else if (req_baro_valid && req_gps_valid)
         pipe_in[0].conf = (adiff < {1'b0, agree_thresh_ff}) ? CONF_AGREE : CONF_DISAGREE;
      else
         pipe_in[0].conf = CONF_SINGLE;

      // first weight: ((gv + bias) << 16 + den/2) / den
      den = 34'(req_baro_var) + 34'(req_gps_var) + 34'(2 * VAR_BIAS);
      pipe_in[0].den = den;
      pipe_in[0].rem = {16'(0), 34'(req_gps_var) + 34'(VAR_BIAS)} << 16;
      pipe_in[0].rem = pipe_in[0].rem + 50'(den >> 1);
   end

   // ---------------- later stages ----------------
   for (genvar k = 1; k < NSTAGE; k++) begin : g_stage
      if ((k >= DIV1_FIRST && k < SETUP2) || (k >= DIV2_FIRST && k < MUL1)) begin : g_div
         localparam int SH = (k < SETUP2) ? (DIV_BITS - 1 - (k - DIV1_FIRST))
                                          : (DIV_BITS - 1 - (k - DIV2_FIRST));
         always_comb begin
            logic [50:0] dsh;
            pipe_in[k] = pipe_ff[k-1];
            dsh = 51'(pipe_ff[k-1].den) << SH;
            // restoring step: subtract shifted divisor where it fits
            if ({1'b0, pipe_ff[k-1].rem} >= dsh) begin
               pipe_in[k].rem     = 50'({1'b0, pipe_ff[k-1].rem} - dsh);
               pipe_in[k].quo[SH] = 1'b1;
            end
         end
      end else if (k == SETUP2) begin : g_setup
         always_comb begin
            logic [16:0] wb;
            logic [16:0] wg;
            logic [17:0] tot;
            pipe_in[k] = pipe_ff[k-1];
            wb = pipe_ff[k-1].quo;
            wg = 17'(ONE_Q16) - wb;
            if (wb < {1'b0, min_weight_ff}) wb = {1'b0, min_weight_ff};
            if (wg < {1'b0, min_weight_ff}) wg = {1'b0, min_weight_ff};
            tot = 18'(wb) + 18'(wg);
            pipe_in[k].den = 34'(tot);
            pipe_in[k].rem = (50'(wb) << 16) + 50'(tot >> 1);
            pipe_in[k].quo = '0;
         end
      end else if (k == MUL1) begin : g_mul1
         always_comb begin
            logic [16:0] wb;
            logic [16:0] wg;
            pipe_in[k] = pipe_ff[k-1];
            wb = pipe_ff[k-1].quo;
            wg = 17'(ONE_Q16) - wb;
            pipe_in[k].wb  = wb;
            pipe_in[k].wg  = wg;
            pipe_in[k].pba = 49'(pipe_ff[k-1].ba) * 49'($signed({1'b0, wb}));
            pipe_in[k].pga = 49'(pipe_ff[k-1].ga) * 49'($signed({1'b0, wg}));
            pipe_in[k].pbv = 49'(pipe_ff[k-1].bv) * 49'(wb);
            pipe_in[k].pgv = 49'(pipe_ff[k-1].gv) * 49'(wg);
         end
      end else if (k == MUL2) begin : g_mul2
         always_comb begin
            logic signed [49:0] s;
            logic [65:0]        prb;
            logic [65:0]        prg;
            pipe_in[k] = pipe_ff[k-1];
            s = 50'(pipe_ff[k-1].pba) + 50'(pipe_ff[k-1].pga) + 50'sd32768;
            pipe_in[k].alt = s[47:16];
            prb = 66'(pipe_ff[k-1].pbv) * 66'(pipe_ff[k-1].wb) + 66'h80000000;
            prg = 66'(pipe_ff[k-1].pgv) * 66'(pipe_ff[k-1].wg) + 66'h80000000;
            pipe_in[k].tb = prb[65:32];
            pipe_in[k].tg = prg[65:32];
         end
      end else begin : g_final
         always_comb begin
            logic [34:0] vsum;
            pipe_in[k] = pipe_ff[k-1];
            vsum = 35'(pipe_ff[k-1].tb) + 35'(pipe_ff[k-1].tg);
            if (pipe_ff[k-1].fuse) begin
               pipe_in[k].var_out = (vsum[34:32] != 3'd0) ? 32'hFFFF_FFFF : vsum[31:0];
               pipe_in[k].degree  = 2'd2;
            end else if (pipe_ff[k-1].bok) begin
               pipe_in[k].alt     = pipe_ff[k-1].ba;
               pipe_in[k].var_out = pipe_ff[k-1].bv;
               pipe_in[k].degree  = 2'd1;
            end else if (pipe_ff[k-1].gok) begin
               pipe_in[k].alt     = pipe_ff[k-1].ga;
               pipe_in[k].var_out = pipe_ff[k-1].gv;
               pipe_in[k].degree  = 2'd1;
            end else begin
               pipe_in[k].alt     = '0;
               pipe_in[k].var_out = '0;
               pipe_in[k].degree  = 2'd0;
            end
         end
      end
   end

   // advance all stages together, hold on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NSTAGE-2:0], req_valid};
      end
   end

   for (genvar k = 0; k < NSTAGE; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (advance) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_valid         = valid_ff[NSTAGE-1];
   assign rsp_fused_alt     = pipe_ff[NSTAGE-1].alt;
   assign rsp_fused_var     = pipe_ff[NSTAGE-1].var_out;
   assign rsp_fusion_degree = pipe_ff[NSTAGE-1].degree;
   assign rsp_baro_health   = pipe_ff[NSTAGE-1].bh;
   assign rsp_gps_health    = pipe_ff[NSTAGE-1].gh;
   assign rsp_confidence    = pipe_ff[NSTAGE-1].conf;

endmodule
